@@ design/mexp_pkg.sv @@
// shared types for the modular exponentiation block
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int unsigned FIELD_BITS = 32;

	// operation codes for the shared modular unit
	typedef enum logic [1:0] {
		OP_MUL = 2'b01,
		OP_RED = 2'b10
	} mexp_op_t;

	typedef struct packed {
		logic     start;
		mexp_op_t op;
	} mexp_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mexp_stat_t;

endpackage

@@ design/mexp_unit.sv @@
// shared modular unit: shift-and-add multiply mod m, and restoring reduction mod m
`timescale 1ns / 1ps

module mexp_unit #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mexp_pkg::mexp_ctl_t ctl,
	input  logic [W-1:0]        a_in,
	input  logic [W-1:0]        b_in,
	input  logic [W-1:0]        m_in,
	output mexp_pkg::mexp_stat_t stat,
	output logic [W-1:0]        result
);
	import mexp_pkg::*;

	localparam int CW = $clog2(W + 1);

	typedef enum logic [2:0] {
		U_IDLE = 3'b001,
		U_MUL  = 3'b010,
		U_RED  = 3'b100
	} unit_state_t;

	unit_state_t  state_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] m_q;
	logic [W-1:0] acc_q;
	logic [CW-1:0] cnt_q;

	logic [W:0]   red_t;
	logic [W:0]   red_diff;
	logic [W-1:0] red_next;
	logic [W-1:0] acc_plus;
	logic [W-1:0] a_dbl;

	// (x + y) mod m for x, y below m
	function automatic logic [W-1:0] add_red(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[W-1:0];
	endfunction

	assign acc_plus = add_red(acc_q, a_q, m_q);
	assign a_dbl    = add_red(a_q, a_q, m_q);

	// one quotient bit a cycle, remainder stays below m
	assign red_t    = {acc_q, a_q[W-1]};
	assign red_diff = red_t - {1'b0, m_q};
	assign red_next = (red_t >= {1'b0, m_q}) ? red_diff[W-1:0] : red_t[W-1:0];

	assign stat.busy = (state_q != U_IDLE);
	assign stat.done = ((state_q == U_MUL) && (b_q == '0)) ||
		((state_q == U_RED) && (cnt_q == '0));
	assign result    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					if (ctl.start) begin
						if (ctl.op == OP_RED) begin
							state_q <= U_RED;
						end else begin
							state_q <= U_MUL;
						end
						cnt_q <= CW'(W);
					end
				end
				U_MUL: begin
					if (b_q == '0) begin
						state_q <= U_IDLE;
					end
				end
				U_RED: begin
					if (cnt_q == '0) begin
						state_q <= U_IDLE;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && ctl.start) begin
			a_q   <= a_in;
			b_q   <= b_in;
			m_q   <= m_in;
			acc_q <= '0;
		end else if (state_q == U_MUL && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_plus;
			end
			a_q <= a_dbl;
			b_q <= b_q >> 1;
		end else if (state_q == U_RED && cnt_q != '0) begin
			acc_q <= red_next;
			a_q   <= a_q << 1;
		end
	end

endmodule

@@ design/modular_exponentiation.sv @@
// modular exponentiation top level: right-to-left binary method around one shared modular unit
// sequence per input beat: a check step, which goes straight to the output for a zero modulus or
//   zero exponent; otherwise a base reduction, then per exponent bit a multiply when the bit is
//   set and a squaring unless it is the top set bit, and finally the output load, which waits
//   while the output register still holds a result that has not been taken
// one item at a time: the next beat is accepted only once the sequencer is back in idle after
//   the result loads; reset clears the sequencers and output valid
`timescale 1ns / 1ps

module modular_exponentiation #(
	parameter int OPERAND_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// base_value [31:0], exponent_value [63:32], modulus_value [95:64]
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// power_result [31:0]
	output logic [31:0] m_tdata,
	// zero_modulus_error [0]
	output logic        m_tuser
);
	import mexp_pkg::*;

	localparam int W = OPERAND_BITS;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_CHK  = 8'b0000_0010,
		S_RED  = 8'b0000_0100,
		S_BIT  = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_SQ0  = 8'b0010_0000,
		S_SQR  = 8'b0100_0000,
		S_FIN  = 8'b1000_0000
	} seq_state_t;

	seq_state_t   state_q;
	logic [W-1:0] base_q;
	logic [W-1:0] exp_q;
	logic [W-1:0] mod_q;
	logic [W-1:0] acc_q;
	logic         err_q;

	logic                      out_valid_q;
	logic [FIELD_BITS-1:0]     out_data_q;
	logic                      out_err_q;

	mexp_ctl_t    u_ctl;
	mexp_stat_t   u_st;
	logic [W-1:0] u_a;
	logic [W-1:0] u_res;
	logic         in_beat;
	logic         out_free;

	assign in_beat  = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		u_ctl.start = 1'b0;
		u_ctl.op    = OP_MUL;
		unique case (state_q)
			S_CHK: begin
				if (mod_q != '0 && exp_q != '0) begin
					u_ctl.start = 1'b1;
					u_ctl.op    = OP_RED;
				end
			end
			S_BIT: begin
				u_ctl.start = exp_q[0];
			end
			S_SQ0: begin
				u_ctl.start = (exp_q[W-1:1] != '0);
			end
			default: begin
				u_ctl.start = 1'b0;
			end
		endcase
	end

	// multiply takes the running result, squaring and reduction take the base
	assign u_a = (state_q == S_BIT) ? acc_q : base_q;

	mexp_unit #(
		.W(W)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (u_ctl),
		.a_in   (u_a),
		.b_in   (base_q),
		.m_in   (mod_q),
		.stat   (u_st),
		.result (u_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (mod_q == '0 || exp_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (u_st.done) begin
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					if (exp_q[0]) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_SQ0;
					end
				end
				S_MUL: begin
					if (u_st.done) begin
						state_q <= S_SQ0;
					end
				end
				S_SQ0: begin
					// last set bit consumed: the trailing square is not needed
					if (exp_q[W-1:1] == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (u_st.done) begin
						state_q <= S_BIT;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			base_q <= W'(s_tdata[31:0]);
			exp_q  <= W'(s_tdata[63:32]);
			mod_q  <= W'(s_tdata[95:64]);
		end
		if (state_q == S_CHK) begin
			err_q <= (mod_q == '0);
			if (mod_q == '0) begin
				acc_q <= '0;
			end else if (exp_q == '0 || mod_q != W'(1)) begin
				acc_q <= W'(1);
			end else begin
				acc_q <= '0;
			end
		end
		if (state_q == S_RED && u_st.done) begin
			base_q <= u_res;
		end
		if (state_q == S_MUL && u_st.done) begin
			acc_q <= u_res;
		end
		if (state_q == S_SQ0) begin
			exp_q <= exp_q >> 1;
		end
		if (state_q == S_SQR && u_st.done) begin
			base_q <= u_res;
		end
	end

	// output register, filled once the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_data_q <= FIELD_BITS'(acc_q);
			out_err_q  <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_err_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error beat carries a nonzero result");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		u_st.done |-> (state_q == S_RED || state_q == S_MUL || state_q == S_SQR))
		else $error("unit finished while sequencer was not waiting");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		u_ctl.start |-> !u_st.busy)
		else $error("unit started while busy");

	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == S_CHK))
		else $error("accepted beat not checked next");

endmodule

@@ verif/tb_modular_exponentiation.sv @@
// testbench for modular_exponentiation: random and corner operand sets checked against a local power predictor
`timescale 1ns / 1ps

module tb_modular_exponentiation;

	localparam int W = mexp_pkg::FIELD_BITS;
	localparam int RANDOM_SETS = 270;
	// the limit covers worst-case sets plus long gaps on both sides
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [W-1:0] base;
		logic [W-1:0] expo;
		logic [W-1:0] modulus;
	} operand_set_t;

	typedef struct {
		operand_set_t ops;
		logic [W-1:0] power;
		logic         zero_mod;
	} power_check_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [3*W-1:0] s_tdata = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [W-1:0]  m_tdata;
	logic          m_tuser;

	operand_set_t  operand_queue[$];
	power_check_t  pending_powers[$];

	bit            in_beat_taken = 1'b0;
	bit            steady_ready = 1'b0;
	int unsigned   send_gap = 0;
	int unsigned   stall_left = 0;
	int unsigned   cycle_count = 0;
	int unsigned   directed_sets = 0;
	int unsigned   sets_sent = 0;
	int unsigned   results_seen = 0;
	int unsigned   zero_mod_sets = 0;
	int unsigned   zero_exp_sets = 0;
	int unsigned   unit_mod_sets = 0;
	int unsigned   fail_count = 0;

	modular_exponentiation #(
		.OPERAND_BITS(W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #10 clk = ~clk;

	// right-to-left square and multiply with exact double-width products
	function automatic power_check_t predict_power(operand_set_t ops);
		power_check_t res;
		logic [2*W-1:0] acc;
		logic [2*W-1:0] sq;
		logic [2*W-1:0] modw;
		logic [W-1:0]   bits;
		res.ops = ops;
		res.zero_mod = 1'b0;
		if (ops.modulus == '0) begin
			res.power = '0;
			res.zero_mod = 1'b1;
		end else if (ops.expo == '0) begin
			// left unreduced, so a modulus of one still gives one
			res.power = 1;
		end else begin
			modw = ops.modulus;
			sq = ops.base % modw;
			acc = 1 % modw;
			bits = ops.expo;
			while (bits != '0) begin
				if (bits[0])
					acc = (acc * sq) % modw;
				sq = (sq * sq) % modw;
				bits = bits >> 1;
			end
			res.power = acc[W-1:0];
		end
		return res;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int unsigned rand_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 4);
		else
			return $urandom_range(10, 60);
	endfunction

	task automatic add_set(input logic [W-1:0] b, input logic [W-1:0] e, input logic [W-1:0] m);
		operand_set_t ops;
		ops.base = b;
		ops.expo = e;
		ops.modulus = m;
		operand_queue.push_back(ops);
	endtask

	// driver: one beat at a time from the operand queue
	always @(negedge clk) begin
		operand_set_t ops;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_beat_taken) begin
			if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap--;
			end else if (operand_queue.size() != 0) begin
				ops = operand_queue.pop_front();
				s_tdata <= {ops.modulus, ops.expo, ops.base};
				s_tvalid <= 1'b1;
				send_gap = rand_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		in_beat_taken = 1'b0;
	end

	// result side backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!steady_ready && $urandom_range(0, 99) < 30) begin
			stall_left = rand_gap();
			if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor: predict on each input beat, compare each result beat
	always @(posedge clk) begin
		operand_set_t in_ops;
		power_check_t want;
		if (arst_n && s_tvalid && s_tready) begin
			in_ops.base = s_tdata[W-1:0];
			in_ops.expo = s_tdata[2*W-1:W];
			in_ops.modulus = s_tdata[3*W-1:2*W];
			pending_powers.push_back(predict_power(in_ops));
			sets_sent++;
			if (in_ops.modulus == '0)
				zero_mod_sets++;
			else if (in_ops.expo == '0)
				zero_exp_sets++;
			else if (in_ops.modulus == 1)
				unit_mod_sets++;
			in_beat_taken = 1'b1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			steady_ready = ($urandom_range(0, 3) == 0);
			if (pending_powers.size() == 0) begin
				$display("%0t: result beat with nothing pending: power_result %h zero_modulus_error %b",
					$time, m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = pending_powers.pop_front();
				if (m_tdata !== want.power) begin
					$display("%0t: power_result expected %h actual %h (base %h exp %h mod %h)",
						$time, want.power, m_tdata, want.ops.base, want.ops.expo, want.ops.modulus);
					fail_count++;
				end
				if (m_tuser !== want.zero_mod) begin
					$display("%0t: zero_modulus_error expected %b actual %b (base %h exp %h mod %h)",
						$time, want.zero_mod, m_tuser, want.ops.base, want.ops.expo, want.ops.modulus);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, pending_powers.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned r;
		logic [W-1:0] b;
		logic [W-1:0] e;
		logic [W-1:0] m;

		// corners: zero modulus, zero exponent, modulus of one, full-width operands
		add_set(32'd5, 32'd3, 32'd13);
		add_set(32'd0, 32'd0, 32'd0);
		add_set(32'd7, 32'd5, 32'd0);
		add_set(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
		add_set(32'd9, 32'd0, 32'd1);
		add_set(32'd9, 32'd0, 32'd100);
		add_set(32'd0, 32'd0, 32'hFFFFFFFF);
		add_set(32'd12345, 32'd7, 32'd1);
		add_set(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
		add_set(32'd0, 32'd5, 32'd97);
		add_set(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_set(32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF);
		add_set(32'd2, 32'd31, 32'hFFFFFFFF);
		add_set(32'hFFFFFFFF, 32'd2, 32'hFFFFFFFB);
		add_set(32'd3, 32'd1, 32'd2);
		add_set(32'd123456789, 32'h80000000, 32'hFFFFFFFB);
		add_set(32'd2, 32'hFFFFFFFF, 32'h80000000);
		add_set(32'd1, 32'hFFFFFFFF, 32'd7);
		add_set(32'hAAAAAAAA, 32'h55555555, 32'h7FFFFFFF);
		add_set(32'd13, 32'd12, 32'd13);
		add_set(32'hDEADBEEF, 32'h00010001, 32'hFFFFFFFE);
		directed_sets = operand_queue.size();

		for (int i = 0; i < RANDOM_SETS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				m = '0;
			else if (r < 10)
				m = 1;
			else if (r < 25)
				m = $urandom_range(2, 255);
			else if (r < 35)
				m = 32'hFFFFFFFF - $urandom_range(0, 15);
			else
				m = $urandom;

			r = $urandom_range(0, 99);
			if (r < 8)
				b = '0;
			else if (r < 16)
				b = $urandom_range(1, 15);
			else if (r < 24)
				b = m * $urandom_range(1, 3);
			else if (r < 30)
				b = m - 1;
			else
				b = $urandom;

			// exponent length sets the run time, so many are shortened
			r = $urandom_range(0, 99);
			if (r < 6)
				e = '0;
			else if (r < 16)
				e = $urandom_range(1, 16);
			else if (r < 50)
				e = $urandom;
			else
				e = $urandom >> $urandom_range(0, 31);

			add_set(b, e, m);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (operand_queue.size() != 0 || s_tvalid || pending_powers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("applied %0d operand sets (%0d corner cases): %0d zero modulus, %0d zero exponent, %0d modulus one",
			sets_sent, directed_sets, zero_mod_sets, zero_exp_sets, unit_mod_sets);
		$display("checked %0d results in %0d cycles with %0d mismatches",
			results_seen, cycle_count, fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ modular_exponentiation.f @@
design/mexp_pkg.sv
design/mexp_unit.sv
design/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
